// ----- rtl/fps_pkg.sv -----
// Shared types and constants of the five-point stencil smoother.
`default_nettype none

package fps_pkg;

    localparam int ROW_W      = 16;
    localparam int OUT_COL_W  = 11;
    localparam int PIX_IO_W   = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int COLS_CFG_W = 12;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS = 2'd1;

    // Number of pixels that enter one mean.
    typedef logic [2:0] cnt_t;

    localparam cnt_t CNT_ONE   = 3'd1;
    localparam cnt_t CNT_TWO   = 3'd2;
    localparam cnt_t CNT_THREE = 3'd3;
    localparam cnt_t CNT_FOUR  = 3'd4;
    localparam cnt_t CNT_FIVE  = 3'd5;

    typedef struct packed {
        logic [ROW_W-1:0]     row;
        logic [OUT_COL_W-1:0] col;
        logic                 done;
        cnt_t                 cnt;
    } job_meta_t;

    typedef struct packed {
        logic [PIX_IO_W-1:0]  pixel;
        logic [ROW_W-1:0]     row;
        logic [OUT_COL_W-1:0] col;
        logic                 done;
    } result_t;

endpackage

`default_nettype wire

// ----- rtl/fps_fifo.sv -----
// Small register queue with full and empty flags.
`default_nettype none

module fps_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire logic [W-1:0] wdata,
    output logic              full,
    input  wire logic         pop,
    output logic [W-1:0]      rdata,
    output logic              empty
);

    localparam int AW = $clog2(DEPTH);

    logic [W-1:0]  store [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW:0]   count_reg;
    logic [AW:0]   count_next;
    logic          wr;
    logic          rd;

    assign full  = (count_reg == (AW+1)'(DEPTH));
    assign empty = (count_reg == '0);
    assign wr    = push && !full;
    assign rd    = pop && !empty;
    assign rdata = store[rd_ptr_reg];

    always_comb
    begin
        case ({wr, rd})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            store[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/fps_front.sv -----
// Front end: raster counters, line store, window registers and job generation.
`default_nettype none

module fps_front #(
    parameter int MAX_COLS   = 2048,
    parameter int PIXEL_BITS = 8
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 restart,
    input  wire logic [fps_pkg::ROW_W-1:0]            frame_rows,
    input  wire logic [$clog2(MAX_COLS):0]            frame_cols,
    input  wire logic                                 push,
    input  wire logic [fps_pkg::PIX_IO_W-1:0]         pixel_in,
    output logic                                      ready,
    output logic                                      job_push,
    output fps_pkg::job_meta_t                        job_meta,
    output logic [PIXEL_BITS+2:0]                     job_sum,
    input  wire logic                                 job_full
);

    localparam int CW    = $clog2(MAX_COLS);
    localparam int CNT_W = CW + 1;
    localparam int PW    = PIXEL_BITS;
    localparam int SUM_W = PW + 3;
    localparam int ROW_W = fps_pkg::ROW_W;

    // Each entry holds {row before previous, previous row} at one column.
    logic [2*PW-1:0] line_mem [MAX_COLS];
    logic [2*PW-1:0] rd_a_reg;
    logic [PW-1:0]   rd_b_reg;

    logic [ROW_W-1:0] row_reg;
    logic [CW-1:0]    col_reg;
    logic [PW-1:0]    lp0_reg;
    logic [PW-1:0]    pd1_reg;
    logic [PW-1:0]    pd2_reg;

    logic [2:0]         pend_valid_reg;
    logic [2:0]         pend_valid_next;
    fps_pkg::job_meta_t pend_meta_reg [3];
    logic [SUM_W-1:0]   pend_sum_reg  [3];

    fps_pkg::job_meta_t new_meta [3];
    logic [SUM_W-1:0]   new_sum  [3];
    logic [2:0]         new_valid;

    logic          acc;
    logic          emit;
    logic          pend_single;
    logic [1:0]    sel;
    logic [PW-1:0] pix;
    logic [PW-1:0] up;
    logic [PW-1:0] mid;
    logic [PW-1:0] rt;
    logic          has_up;
    logic          has_up2;
    logic          has_left;
    logic          has_ll;
    logic          last_row;
    logic          last_col;
    logic [CW-1:0] col_n;
    logic [CW-1:0] col_nb;

    assign pix = PW'(pixel_in);
    assign up  = rd_a_reg[2*PW-1:PW];
    assign mid = rd_a_reg[PW-1:0];
    assign rt  = rd_b_reg;

    assign has_up   = (row_reg != '0);
    assign has_up2  = (row_reg > ROW_W'(1));
    assign has_left = (col_reg != '0);
    assign has_ll   = (CNT_W'(col_reg) > CNT_W'(1));
    assign last_row = (row_reg == frame_rows - ROW_W'(1));
    assign last_col = (CNT_W'(col_reg) == frame_cols - CNT_W'(1));
    assign col_n    = last_col ? '0 : col_reg + CW'(1);
    assign col_nb   = col_n + CW'(1);

    // Hold the next item until no job is pending, or one is left and it leaves now.
    assign pend_single = (pend_valid_reg != '0)
                      && ((pend_valid_reg & (pend_valid_reg - 3'd1)) == 3'd0);
    assign ready    = (pend_valid_reg == '0) || (pend_single && !job_full);
    assign acc      = push && ready;
    assign emit     = (pend_valid_reg != '0) && !job_full;
    assign job_push = emit;

    always_comb
    begin
        if (pend_valid_reg[0])
        begin
            sel = 2'd0;
        end
        else if (pend_valid_reg[1])
        begin
            sel = 2'd1;
        end
        else
        begin
            sel = 2'd2;
        end
    end

    assign job_meta = pend_meta_reg[sel];
    assign job_sum  = pend_sum_reg[sel];

    always_comb
    begin
        // Pixel one row up, at this column.
        new_valid[0]     = has_up;
        new_sum[0]       = SUM_W'(mid) + SUM_W'(pix)
                         + (has_up2 ? SUM_W'(up) : '0)
                         + (has_left ? SUM_W'(lp0_reg) : '0)
                         + (!last_col ? SUM_W'(rt) : '0);
        new_meta[0].cnt  = 3'd2 + 3'(has_up2) + 3'(has_left) + 3'(!last_col);
        new_meta[0].row  = row_reg - ROW_W'(1);
        new_meta[0].col  = fps_pkg::OUT_COL_W'(col_reg);
        new_meta[0].done = 1'b0;

        // Last row: pixel to the left in this row.
        new_valid[1]     = last_row && has_left;
        new_sum[1]       = SUM_W'(pd1_reg) + SUM_W'(pix)
                         + (has_up ? SUM_W'(lp0_reg) : '0)
                         + (has_ll ? SUM_W'(pd2_reg) : '0);
        new_meta[1].cnt  = 3'd2 + 3'(has_up) + 3'(has_ll);
        new_meta[1].row  = row_reg;
        new_meta[1].col  = fps_pkg::OUT_COL_W'(col_reg - CW'(1));
        new_meta[1].done = 1'b0;

        // Final pixel of the frame.
        new_valid[2]     = last_row && last_col;
        new_sum[2]       = SUM_W'(pix)
                         + (has_up ? SUM_W'(mid) : '0)
                         + (has_left ? SUM_W'(pd1_reg) : '0);
        new_meta[2].cnt  = 3'd1 + 3'(has_up) + 3'(has_left);
        new_meta[2].row  = row_reg;
        new_meta[2].col  = fps_pkg::OUT_COL_W'(col_reg);
        new_meta[2].done = 1'b1;
    end

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        if (emit)
        begin
            pend_valid_next[sel] = 1'b0;
        end
        if (acc)
        begin
            pend_valid_next = new_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg        <= '0;
            col_reg        <= '0;
            pend_valid_reg <= '0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            if (restart)
            begin
                row_reg <= '0;
                col_reg <= '0;
            end
            else if (acc)
            begin
                col_reg <= col_n;
                if (last_col)
                begin
                    row_reg <= last_row ? '0 : row_reg + ROW_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pend_meta_reg[i] <= new_meta[i];
                pend_sum_reg[i]  <= new_sum[i];
            end
            lp0_reg <= mid;
            pd1_reg <= pix;
            pd2_reg <= pd1_reg;
        end
    end

    // Read ahead the two entries the next item needs; forward the entry
    // written in the same cycle.
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            line_mem[col_reg] <= {mid, pix};
            rd_a_reg <= (col_n == col_reg) ? {mid, pix} : line_mem[col_n];
            rd_b_reg <= (col_nb == col_reg) ? pix : line_mem[col_nb][PW-1:0];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/fps_back.sv -----
// Back end: divides each job sum by its pixel count through a reciprocal product.
`default_nettype none

module fps_back #(
    parameter int PIXEL_BITS = 8
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   job_empty,
    input  wire fps_pkg::job_meta_t     job_meta,
    input  wire logic [PIXEL_BITS+2:0]  job_sum,
    output logic                        job_pop,
    output logic                        res_push,
    output fps_pkg::result_t            res_data,
    input  wire logic                   res_full
);

    localparam int SUM_W  = PIXEL_BITS + 3;
    localparam int K      = SUM_W + 3;
    localparam int M_W    = K + 1;
    localparam int PROD_W = SUM_W + M_W;

    localparam logic [M_W-1:0] M_DIV1 = M_W'(1) << K;
    localparam logic [M_W-1:0] M_DIV2 = M_W'(1) << (K - 1);
    localparam logic [M_W-1:0] M_DIV4 = M_W'(1) << (K - 2);
    localparam logic [M_W-1:0] M_DIV3 = M_W'((2 ** K) / 3 + 1);
    localparam logic [M_W-1:0] M_DIV5 = M_W'((2 ** K) / 5 + 1);

    logic               s1_valid_reg;
    logic [PROD_W-1:0]  s1_prod_reg;
    fps_pkg::job_meta_t s1_meta_reg;
    logic [M_W-1:0]     m_sel;
    logic               take;

    always_comb
    begin
        unique case (job_meta.cnt)
            fps_pkg::CNT_ONE:   m_sel = M_DIV1;
            fps_pkg::CNT_TWO:   m_sel = M_DIV2;
            fps_pkg::CNT_THREE: m_sel = M_DIV3;
            fps_pkg::CNT_FOUR:  m_sel = M_DIV4;
            fps_pkg::CNT_FIVE:  m_sel = M_DIV5;
            default:            m_sel = M_DIV1;
        endcase
    end

    assign res_push = s1_valid_reg && !res_full;
    assign take     = !job_empty && (!s1_valid_reg || !res_full);
    assign job_pop  = take;

    assign res_data.pixel = fps_pkg::PIX_IO_W'(s1_prod_reg[K +: SUM_W]);
    assign res_data.row   = s1_meta_reg.row;
    assign res_data.col   = s1_meta_reg.col;
    assign res_data.done  = s1_meta_reg.done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (res_push)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_prod_reg <= PROD_W'(job_sum) * PROD_W'(m_sel);
            s1_meta_reg <= job_meta;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/five_point_stencil_smoother_core.sv -----
// Top level of the five-point stencil smoother: config registers and queues.
//
//   channel   direction  handshake              payload
//   input     in         push / full            pixel_in
//   result    out        empty / pop            pixel_out, out_row, out_col, frame_done
//   config    in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A new item waits until the results of the last item have left or the last one leaves now;
// first-row items yield none unless that row is the last, later rows one, and the last row up to two more.
// Input reaches the result queue through the job build registers, the job queue and the divide stage.
// Reset clears counters and queues at once; line store contents are not cleared.
// A full result queue stalls the divide stage, then the job queue, then input.
`default_nettype none

module five_point_stencil_smoother_core #(
    parameter int MAX_COLS   = 2048,
    parameter int PIXEL_BITS = 8
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               push,
    output logic                                    full,
    input  wire logic [fps_pkg::PIX_IO_W-1:0]       pixel_in,
    output logic                                    empty,
    input  wire logic                               pop,
    output logic [fps_pkg::PIX_IO_W-1:0]            pixel_out,
    output logic [fps_pkg::ROW_W-1:0]               out_row,
    output logic [fps_pkg::OUT_COL_W-1:0]           out_col,
    output logic                                    frame_done,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [fps_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [fps_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int CNT_W     = $clog2(MAX_COLS) + 1;
    localparam int SUM_W     = PIXEL_BITS + 3;
    localparam int META_W    = $bits(fps_pkg::job_meta_t);
    localparam int JOB_W     = META_W + SUM_W;
    localparam int RES_W     = $bits(fps_pkg::result_t);
    localparam int JOB_DEPTH = 4;
    localparam int RES_DEPTH = 4;

    logic [fps_pkg::ROW_W-1:0]      frame_rows_reg;
    logic [CNT_W-1:0]               frame_cols_reg;
    logic [fps_pkg::COLS_CFG_W-1:0] cols_raw;
    logic [CNT_W-1:0]               cols_eff;
    logic                           cfg_wr;
    logic                           restart;

    logic               front_ready;
    logic               job_push;
    fps_pkg::job_meta_t front_meta;
    logic [SUM_W-1:0]   front_sum;
    logic               job_full;
    logic               job_empty;
    logic               job_pop;
    logic [JOB_W-1:0]   job_rdata;

    logic               res_push;
    fps_pkg::result_t   res_wdata;
    logic               res_full;
    logic [RES_W-1:0]   res_rdata;
    fps_pkg::result_t   res_head;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign restart   = cfg_wr && ((cfg_index == fps_pkg::REG_FRAME_ROWS)
                               || (cfg_index == fps_pkg::REG_FRAME_COLS));

    // Map zero to one column and clip widths beyond the line store.
    assign cols_raw = cfg_data[fps_pkg::COLS_CFG_W-1:0];
    always_comb
    begin
        if (cols_raw == '0)
        begin
            cols_eff = CNT_W'(1);
        end
        else if (32'(cols_raw) > 32'(MAX_COLS))
        begin
            cols_eff = CNT_W'(MAX_COLS);
        end
        else
        begin
            cols_eff = CNT_W'(cols_raw);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_rows_reg <= fps_pkg::ROW_W'(1);
            frame_cols_reg <= CNT_W'(1);
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                fps_pkg::REG_FRAME_ROWS:
                begin
                    frame_rows_reg <= (cfg_data == '0) ? fps_pkg::ROW_W'(1) : cfg_data;
                end
                fps_pkg::REG_FRAME_COLS:
                begin
                    frame_cols_reg <= cols_eff;
                end
                default:
                begin
                    frame_rows_reg <= frame_rows_reg;
                end
            endcase
        end
    end

    assign full = !front_ready;

    fps_front #(
        .MAX_COLS   (MAX_COLS),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .restart    (restart),
        .frame_rows (frame_rows_reg),
        .frame_cols (frame_cols_reg),
        .push       (push),
        .pixel_in   (pixel_in),
        .ready      (front_ready),
        .job_push   (job_push),
        .job_meta   (front_meta),
        .job_sum    (front_sum),
        .job_full   (job_full)
    );

    fps_fifo #(
        .W     (JOB_W),
        .DEPTH (JOB_DEPTH)
    ) u_job_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (job_push),
        .wdata ({front_meta, front_sum}),
        .full  (job_full),
        .pop   (job_pop),
        .rdata (job_rdata),
        .empty (job_empty)
    );

    fps_back #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_empty (job_empty),
        .job_meta  (fps_pkg::job_meta_t'(job_rdata[SUM_W +: META_W])),
        .job_sum   (job_rdata[SUM_W-1:0]),
        .job_pop   (job_pop),
        .res_push  (res_push),
        .res_data  (res_wdata),
        .res_full  (res_full)
    );

    fps_fifo #(
        .W     (RES_W),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_wdata),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_rdata),
        .empty (empty)
    );

    assign res_head   = fps_pkg::result_t'(res_rdata);
    assign pixel_out  = res_head.pixel;
    assign out_row    = res_head.row;
    assign out_col    = res_head.col;
    assign frame_done = res_head.done;

endmodule

`default_nettype wire
